### hw/rtl/sha256_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, constants and round functions of the stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;
  localparam int DigestWords = 8;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE    = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_OUTPUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic absorb;      // write the input byte, count bits
    logic start;       // load block into schedule and working vars
    logic round;       // run one round
    logic fold;        // add working vars into chain value
    logic pad_first;   // write pad byte and zero fill of the tail
    logic pad_zero;    // zero whole buffer before length block
    logic pad_len;     // write length into last eight bytes
    logic clear;       // back to initial state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       block_full;  // next byte is the last one of the block
    logic       last_round;
    logic       len_fits;    // pad byte position below the length field
  } dp_status_t;

  localparam logic [31:0] INIT_H [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial SHA-256 hasher with padding and digest output
// ----------------------------------------------------------------------------
// Usage: each slave item carries kind in tuser and a byte in tdata. A data
// item appends the byte; the 64th byte of a block starts a compression of 64
// rounds, one per cycle, during which s_tready is low.
// A data item that does not fill a block leaves s_tready high.
// A finish item pads the message and compresses one or two blocks, then
// presents the eight digest words on the master side, word 0 first,
// word_index in tuser and tlast on word 7. Each word stays until
// m_tready takes it; a stall simply holds the word and the input stays
// closed until the last word is taken. After that the block is back in its
// initial state for the next message. Reset (rst, synchronous) loads the
// initial hash values and clears the byte and bit counts; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // digest_word
  output logic [2:0]       m_tuser,   // word_index
  output logic             m_tlast    // last_word
);
  import sha256_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [2:0] out_idx;
  logic       in_fire, out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_kind  (s_tuser),
    .out_fire (out_fire),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_idx  (out_idx)
  );

  sha256_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_byte  (s_tdata),
    .out_idx    (out_idx),
    .status     (status),
    .digest_word(m_tdata)
  );

  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == 3'd7);

  // input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input open while digest pending");

  // word index advances by one on each taken word
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_fire && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest word order broken");

  // after the last word the input reopens
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_tlast |=> s_tready && !m_tvalid)
    else $error("no return to idle after digest");

endmodule
`default_nettype wire

### hw/rtl/sha256_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequencer for absorb, compression, padding and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_fire,
  input  wire logic                   in_kind,
  input  wire logic                   out_fire,
  input  wire sha256_pkg::dp_status_t status,
  output sha256_pkg::dp_cmd_t         cmd,
  output logic                        in_ready,
  output logic                        out_valid,
  output logic [2:0]                  out_idx
);
  import sha256_pkg::*;

  state_t     state, state_next;
  logic       final_blk, final_blk_next;  // compressing the length block
  logic       need_len, need_len_next;    // length block still to come
  logic [2:0] idx, idx_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      final_blk <= 1'b0;
      need_len  <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      final_blk <= final_blk_next;
      need_len  <= need_len_next;
      idx       <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    final_blk_next = final_blk;
    need_len_next  = need_len;
    idx_next       = idx;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_FINISH) begin
            state_next     = ST_COMPRESS;
            final_blk_next = status.len_fits;
            need_len_next  = !status.len_fits;
          end else if (status.block_full) begin
            state_next     = ST_COMPRESS;
            final_blk_next = 1'b0;
            need_len_next  = 1'b0;
          end
        end
      end
      ST_COMPRESS: begin
        if (status.last_round) state_next = ST_PAD;
      end
      ST_PAD: begin
        // fold happens here; then choose what follows
        if (need_len) begin
          state_next     = ST_COMPRESS;
          need_len_next  = 1'b0;
          final_blk_next = 1'b1;
        end else if (final_blk) begin
          state_next = ST_OUTPUT;
          idx_next   = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUTPUT: begin
        if (out_fire) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            state_next     = ST_IDLE;
            final_blk_next = 1'b0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_idx   = idx;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.absorb    = (in_kind == KIND_DATA);
          cmd.pad_first = (in_kind == KIND_FINISH);
          cmd.pad_len   = (in_kind == KIND_FINISH) && status.len_fits;
          cmd.start     = (in_kind == KIND_FINISH) ||
                          ((in_kind == KIND_DATA) && status.block_full);
        end
      end
      ST_COMPRESS: cmd.round = 1'b1;
      ST_PAD: begin
        cmd.fold = 1'b1;
        if (need_len) begin
          cmd.pad_zero = 1'b1;
          cmd.pad_len  = 1'b1;
          cmd.start    = 1'b1;
        end
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        cmd.clear = out_fire && (idx == 3'd7);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/sha256_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// block buffer, rolling message schedule, round unit and chain value
// ----------------------------------------------------------------------------
module sha256_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha256_pkg::dp_cmd_t    cmd,
  input  wire logic [7:0]             data_byte,
  input  wire logic [2:0]             out_idx,
  output sha256_pkg::dp_status_t      status,
  output logic [31:0]                 digest_word
);
  import sha256_pkg::*;

  logic [5:0]  count;
  logic [63:0] msg_bits;
  logic [31:0] chain [DigestWords];
  logic [31:0] wv    [DigestWords];
  logic [31:0] sched [BlockBytes/4];
  logic [5:0]  rnd;

  logic [31:0] blk [BlockBytes/4];
  logic [31:0] w_new, t1, t2;

  // block words with the input byte and the padding overlaid
  always_comb begin
    for (int i = 0; i < BlockBytes/4; i++) begin
      blk[i] = sched[i];
      for (int j = 0; j < 4; j++) begin
        if (cmd.absorb && (4*i+j) == int'(count)) blk[i][31-8*j -: 8] = data_byte;
        if (cmd.pad_zero) blk[i][31-8*j -: 8] = 8'h00;
        if (cmd.pad_first) begin
          if ((4*i+j) == int'(count)) blk[i][31-8*j -: 8] = PAD_BYTE;
          else if ((4*i+j) > int'(count)) blk[i][31-8*j -: 8] = 8'h00;
        end
        if (cmd.pad_len && (4*i+j) >= 56)
          blk[i][31-8*j -: 8] = msg_bits[8*(63-(4*i+j)) +: 8];
      end
    end
  end

  // round unit on the current schedule head
  always_comb begin
    w_new = sched[0] + sig0(sched[1]) + sched[9] + sig1(sched[14]);
    t1 = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
         + ROUND_K[rnd] + sched[0];
    t2 = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // byte and bit counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      msg_bits <= '0;
    end else if (cmd.absorb) begin
      count    <= count + 6'd1;
      msg_bits <= msg_bits + 64'd8;
    end
  end

  // schedule window, doubling as block buffer, and working variables
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.start) begin
      rnd <= '0;
    end else if (cmd.round) begin
      rnd <= rnd + 6'd1;
    end
    if (cmd.start) begin
      for (int i = 0; i < BlockBytes/4; i++) sched[i] <= blk[i];
      for (int i = 0; i < DigestWords; i++)
        wv[i] <= cmd.fold ? chain[i] + wv[i] : chain[i];
    end else if (cmd.round) begin
      for (int i = 0; i < BlockBytes/4 - 1; i++) sched[i] <= sched[i+1];
      sched[BlockBytes/4 - 1] <= w_new;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end else if (cmd.absorb) begin
      sched[count[5:2]] <= blk[count[5:2]];
    end
  end

  // chain value
  always_ff @(posedge clk) begin
    for (int i = 0; i < DigestWords; i++) begin
      if (rst || cmd.clear) chain[i] <= INIT_H[i];
      else if (cmd.fold) chain[i] <= chain[i] + wv[i];
    end
  end

  assign status.block_full = (count == 6'd63);
  assign status.last_round = (rnd == 6'd63);
  assign status.len_fits   = (count < 6'd56);
  assign digest_word       = chain[out_idx];

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives byte and finish items into the stream hasher, predicts each digest
// with an independent sha-256 model and checks every digest word in order
// ----------------------------------------------------------------------------
module testbench;
  import sha256_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KT [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  msg_item_t    pending_items[$];
  digest_item_t expected_words[$];
  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill_count;
  logic [63:0]  bit_count;
  int           errors = 0;
  int           send_idle_pct = 7;
  int           recv_idle_pct = 49;
  int           hold_off = 0;
  bit           hold_req = 1'b0;
  bit           hold_taken = 1'b0;
  int unsigned  cycle_count = 0;

  sha256_stream_hasher DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),   // data_byte
    .s_tuser(s_tuser),   // kind
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata),   // digest_word
    .m_tuser(m_tuser),   // word_index
    .m_tlast(m_tlast)    // last_word
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one sha-256 compression of the model block into the model chain
  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + KT[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = H0[i];
    fill_count = 0;
    bit_count = '0;
  endtask

  // absorb one accepted item, queue the digest on a finish
  task automatic predict_digest(input msg_item_t it);
    int unsigned n;
    digest_item_t dw;
    if (it.kind == KIND_DATA) begin
      block_bytes[fill_count[5:0]] = it.data_byte;
      bit_count += 64'd8;
      fill_count++;
      if (fill_count == 64) begin
        hash_block();
        fill_count = 0;
      end
    end else begin
      n = fill_count;
      block_bytes[n[5:0]] = PAD_BYTE;
      n++;
      if (n > 56) begin
        while (n < 64) begin
          block_bytes[n[5:0]] = 8'h00;
          n++;
        end
        hash_block();
        n = 0;
      end
      while (n < 56) begin
        block_bytes[n[5:0]] = 8'h00;
        n++;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_count[63-8*i -: 8];
      hash_block();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = hash_state[i];
        dw.word_index = i[2:0];
        dw.last_word = (i == 7);
        expected_words.insert(expected_words.size(), dw);
      end
      restart_hash();
    end
  endtask

  task automatic add_message(input int len, input int mode);
    msg_item_t it;
    it.kind = KIND_DATA;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.data_byte = 8'h00;
        1: it.data_byte = 8'hff;
        default: it.data_byte = 8'($urandom_range(0, 255));
      endcase
      pending_items.insert(pending_items.size(), it);
    end
    it.kind = KIND_FINISH;
    it.data_byte = 8'($urandom_range(0, 255));
    pending_items.insert(pending_items.size(), it);
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_digest({s_tuser, s_tdata});
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 &&
          ((s_tvalid && !s_tready) || $urandom_range(0, 99) >= send_idle_pct)) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].kind;
        s_tdata <= pending_items[0].data_byte;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_off <= 600;
      hold_taken <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("digest word with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          digest_item_t ex;
          ex = expected_words.pop_front();
          if (m_tdata !== ex.digest_word) begin
            $error("digest_word expected %h actual %h", ex.digest_word, m_tdata);
            errors++;
          end
          if (m_tuser !== ex.word_index) begin
            $error("word_index expected %0d actual %0d", ex.word_index, m_tuser);
            errors++;
          end
          if (m_tlast !== ex.last_word) begin
            $error("last_word expected %0d actual %0d", ex.last_word, m_tlast);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_tvalid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int len;
    restart_hash();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, extra length block, full block
    add_message(0, 2);
    add_message(57, 1);
    add_message(64, 2);
    wait_drained();

    // short random messages, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 7 : 0;
      for (int m = 0; m < 2; m++) begin
        len = $urandom_range(0, 2);
        add_message(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
      end
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        hold_req = 1'b1;
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
